// ===== hdl/pim_pkg.sv =====
// Package for the point-in-moment-ellipse block: payload types, register
// indexes and fixed widths. No dependencies; every other file imports it.
package pim_pkg;

   // Coordinate width of points and centre (signed, 8 fraction bits)
   localparam int COORD_BITS = 24;

   // Limb width of the partial-product multiplier
   localparam int MUL_LIMB_W = 32;

   // Register index width and register map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_CENTRE_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTRE_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MOMENT_XX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MOMENT_YY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MOMENT_XY = 3'd4;

   // One query point
   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
   } req_payload_type;

   // One test result
   typedef struct packed {
      logic inside_res;
      logic bad_shape;
   } rsp_payload_type;

endpackage

// ===== hdl/pim_mul.sv =====
// Two-stage signed multiplier built from limb partial products.
// Depends on pim_pkg for the limb width.
module pim_mul #(
   parameter int A_W = 25,
   parameter int B_W = 25
) (
   input  logic                      clock,
   input  logic signed [A_W-1:0]     a,
   input  logic signed [B_W-1:0]     b,
   output logic signed [A_W+B_W-1:0] p
);
   import pim_pkg::*;

   localparam int PW  = A_W + B_W;
   // Low limbs are unsigned, the top limb keeps one extra bit for the sign
   localparam int KA  = (A_W > 1) ? ((A_W - 2) / MUL_LIMB_W + 1) : 1;
   localparam int KB  = (B_W > 1) ? ((B_W - 2) / MUL_LIMB_W + 1) : 1;
   localparam int AXW = KA * MUL_LIMB_W + 1;
   localparam int BXW = KB * MUL_LIMB_W + 1;
   localparam int LW  = MUL_LIMB_W + 1;
   localparam int PPW = 2 * LW;
   localparam int TW  = PW + PPW;

   logic signed [AXW-1:0] ax;
   logic signed [BXW-1:0] bx;
   logic signed [LW-1:0]  a_limb [KA];
   logic signed [LW-1:0]  b_limb [KB];
   logic signed [PPW-1:0] pp_ff  [KA][KB];
   logic signed [PPW-1:0] pp_in  [KA][KB];
   logic signed [TW-1:0]  acc;
   logic signed [PW-1:0]  p_ff, p_in;

   assign ax = AXW'(a);
   assign bx = BXW'(b);

   // Cut both operands into limbs
   always_comb begin
      for (int i = 0; i < KA; i++) begin
         if (i == KA - 1) a_limb[i] = ax[i*MUL_LIMB_W +: LW];
         else             a_limb[i] = {1'b0, ax[i*MUL_LIMB_W +: MUL_LIMB_W]};
      end
      for (int j = 0; j < KB; j++) begin
         if (j == KB - 1) b_limb[j] = bx[j*MUL_LIMB_W +: LW];
         else             b_limb[j] = {1'b0, bx[j*MUL_LIMB_W +: MUL_LIMB_W]};
      end
   end

   // Form the partial products
   always_comb begin
      for (int i = 0; i < KA; i++) begin
         for (int j = 0; j < KB; j++) begin
            pp_in[i][j] = a_limb[i] * b_limb[j];
         end
      end
   end

   // Align and add the partial products; the product fits in PW bits
   always_comb begin
      acc = '0;
      for (int i = 0; i < KA; i++) begin
         for (int j = 0; j < KB; j++) begin
            acc = acc + (TW'(pp_ff[i][j]) <<< ((i + j) * MUL_LIMB_W));
         end
      end
      p_in = acc[PW-1:0];
   end

   // Advance both stages every cycle
   always_ff @(posedge clock) begin
      pp_ff <= pp_in;
      p_ff  <= p_in;
   end

   assign p = p_ff;

endmodule

// ===== hdl/pim_csr.sv =====
// APB-style register file holding the ellipse centre and moments.
// Depends on pim_pkg for the register map and coordinate width.
module pim_csr #(
   parameter int MOMENT_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [((MOMENT_BITS > 32) ? 3 : 2) + pim_pkg::CSR_IDX_W - 1:0] csr_paddr,
   input  logic [((MOMENT_BITS > 32) ? 64 : 32)-1:0] csr_pwdata,
   output logic [((MOMENT_BITS > 32) ? 64 : 32)-1:0] csr_prdata,
   output logic                                    csr_pready,
   output logic signed [pim_pkg::COORD_BITS-1:0]   centre_x,
   output logic signed [pim_pkg::COORD_BITS-1:0]   centre_y,
   output logic [MOMENT_BITS-1:0]                  moment_xx,
   output logic [MOMENT_BITS-1:0]                  moment_yy,
   output logic signed [MOMENT_BITS-1:0]           moment_xy
);
   import pim_pkg::*;

   localparam int DATA_W   = (MOMENT_BITS > 32) ? 64 : 32;
   localparam int ADDR_LSB = (MOMENT_BITS > 32) ? 3 : 2;
   localparam int ADDR_W   = ADDR_LSB + CSR_IDX_W;

   logic [COORD_BITS-1:0]  centre_x_ff, centre_x_in;
   logic [COORD_BITS-1:0]  centre_y_ff, centre_y_in;
   logic [MOMENT_BITS-1:0] moment_xx_ff, moment_xx_in;
   logic [MOMENT_BITS-1:0] moment_yy_ff, moment_yy_in;
   logic [MOMENT_BITS-1:0] moment_xy_ff, moment_xy_in;
   logic [CSR_IDX_W-1:0]   idx;
   logic                   wr_en;

   assign idx   = csr_paddr[ADDR_W-1:ADDR_LSB];
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   // Decode writes; indexes past the map are dropped
   always_comb begin
      centre_x_in  = centre_x_ff;
      centre_y_in  = centre_y_ff;
      moment_xx_in = moment_xx_ff;
      moment_yy_in = moment_yy_ff;
      moment_xy_in = moment_xy_ff;
      if (wr_en) begin
         case (idx)
            REG_CENTRE_X:  centre_x_in  = csr_pwdata[COORD_BITS-1:0];
            REG_CENTRE_Y:  centre_y_in  = csr_pwdata[COORD_BITS-1:0];
            REG_MOMENT_XX: moment_xx_in = csr_pwdata[MOMENT_BITS-1:0];
            REG_MOMENT_YY: moment_yy_in = csr_pwdata[MOMENT_BITS-1:0];
            REG_MOMENT_XY: moment_xy_in = csr_pwdata[MOMENT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Hold the registers, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff  <= '0;
         centre_y_ff  <= '0;
         moment_xx_ff <= '0;
         moment_yy_ff <= '0;
         moment_xy_ff <= '0;
      end else begin
         centre_x_ff  <= centre_x_in;
         centre_y_ff  <= centre_y_in;
         moment_xx_ff <= moment_xx_in;
         moment_yy_ff <= moment_yy_in;
         moment_xy_ff <= moment_xy_in;
      end
   end

   // Read back the stored bits
   always_comb begin
      case (idx)
         REG_CENTRE_X:  csr_prdata = DATA_W'(centre_x_ff);
         REG_CENTRE_Y:  csr_prdata = DATA_W'(centre_y_ff);
         REG_MOMENT_XX: csr_prdata = DATA_W'(moment_xx_ff);
         REG_MOMENT_YY: csr_prdata = DATA_W'(moment_yy_ff);
         REG_MOMENT_XY: csr_prdata = DATA_W'(moment_xy_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign centre_x   = centre_x_ff;
   assign centre_y   = centre_y_ff;
   assign moment_xx  = moment_xx_ff;
   assign moment_yy  = moment_yy_ff;
   assign moment_xy  = moment_xy_ff;

endmodule

// ===== hdl/point_in_moment_ellipse.sv =====
// Top level of the point-in-moment-ellipse test: eight-stage pipeline.
// Depends on pim_pkg, pim_mul and pim_csr.
//
//   channel   ports                       handshake
//   request   start, busy, req_data       taken when start & !busy
//   result    rsp_strobe, rsp_data        one cycle per item, never held
//   config    csr_* (APB-style)           written at psel&penable&pwrite
//
// One point enters every cycle while busy is low. The pipeline is formed by
// two chained limb multipliers of two stages each, plus offset, determinant,
// form-sum and compare stages.
// Reset is synchronous; busy is high for the cycle after reset only.
// The receiver cannot stall, so the pipeline advances every cycle.
module point_in_moment_ellipse #(
   parameter int MOMENT_BITS = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  pim_pkg::req_payload_type                  req_data,
   output logic                                      rsp_strobe,
   output pim_pkg::rsp_payload_type                  rsp_data,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [((MOMENT_BITS > 32) ? 3 : 2) + pim_pkg::CSR_IDX_W - 1:0] csr_paddr,
   input  logic [((MOMENT_BITS > 32) ? 64 : 32)-1:0] csr_pwdata,
   output logic [((MOMENT_BITS > 32) ? 64 : 32)-1:0] csr_prdata,
   output logic                                      csr_pready
);
   import pim_pkg::*;

   localparam int STAGES = 8;
   localparam int DW     = COORD_BITS + 1;        // point offset
   localparam int SW     = 2 * DW;                // offset products
   localparam int MW     = MOMENT_BITS + 1;       // moments as signed
   localparam int DETW   = 2 * MW + 1;            // determinant
   localparam int TAW    = MW + SW;               // Iyy*dx^2, Ixx*dy^2
   localparam int TCW    = MOMENT_BITS + SW;      // Ixy*dx*dy
   localparam int QW     = MOMENT_BITS + SW + 3;  // quadratic form
   localparam int CMPW   = (QW > DETW) ? QW : DETW;
   localparam int SUMW   = ((SW + 1 > MOMENT_BITS + 2) ? SW + 1 : MOMENT_BITS + 2) + 1;

   logic signed [COORD_BITS-1:0]  centre_x, centre_y;
   logic [MOMENT_BITS-1:0]        moment_xx, moment_yy;
   logic signed [MOMENT_BITS-1:0] moment_xy;
   logic signed [MW-1:0]          ixx_s, iyy_s;
   logic signed [SUMW-1:0]        mom_sum;

   logic                  busy_ff;
   logic                  accept;
   logic [STAGES-1:0]     vld_ff, vld_in;

   logic signed [DW-1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic signed [SW-1:0]          dx2_p, dy2_p, dxy_p;
   logic signed [2*MW-1:0]        xxyy_p;
   logic signed [2*MOMENT_BITS-1:0] xyxy_p;
   logic signed [DETW-1:0]        det_ff, det_in, det_d1_ff, det_d2_ff, det_d3_ff;
   logic signed [SW-1:0]          dx2_ff, dy2_ff, dxy_ff;
   logic signed [SW:0]            sq_ff, sq_in, sq_d1_ff, sq_d2_ff, sq_d3_ff;
   logic signed [TAW-1:0]         ta_p, tb_p;
   logic signed [TCW-1:0]         tc_p;
   logic signed [QW-1:0]          q_ff, q_in;
   rsp_payload_type               rsp_ff, rsp_in;

   // Configuration registers
   pim_csr #(.MOMENT_BITS(MOMENT_BITS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .centre_x    (centre_x),
      .centre_y    (centre_y),
      .moment_xx   (moment_xx),
      .moment_yy   (moment_yy),
      .moment_xy   (moment_xy)
   );

   assign ixx_s   = {1'b0, moment_xx};
   assign iyy_s   = {1'b0, moment_yy};
   assign mom_sum = SUMW'(ixx_s) + SUMW'(iyy_s);

   // Accept control and valid line
   assign accept = start & ~busy_ff;
   assign vld_in = {vld_ff[STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= vld_in;
      end
   end

   // Stage 1: offset of the point from the centre
   assign dx_in = DW'(req_data.point_x) - DW'(centre_x);
   assign dy_in = DW'(req_data.point_y) - DW'(centre_y);

   // Stages 2-3: offset products and determinant products
   pim_mul #(.A_W(DW), .B_W(DW)) u_mul_dx2 (
      .clock(clock), .a(dx_ff), .b(dx_ff), .p(dx2_p));
   pim_mul #(.A_W(DW), .B_W(DW)) u_mul_dy2 (
      .clock(clock), .a(dy_ff), .b(dy_ff), .p(dy2_p));
   pim_mul #(.A_W(DW), .B_W(DW)) u_mul_dxy (
      .clock(clock), .a(dx_ff), .b(dy_ff), .p(dxy_p));
   pim_mul #(.A_W(MW), .B_W(MW)) u_mul_xxyy (
      .clock(clock), .a(ixx_s), .b(iyy_s), .p(xxyy_p));
   pim_mul #(.A_W(MOMENT_BITS), .B_W(MOMENT_BITS)) u_mul_xyxy (
      .clock(clock), .a(moment_xy), .b(moment_xy), .p(xyxy_p));

   // Stage 4: determinant and squared distance
   assign det_in = DETW'(xxyy_p) - DETW'(xyxy_p);
   assign sq_in  = (SW + 1)'(dx2_p) + (SW + 1)'(dy2_p);

   // Stages 5-6: moment-weighted terms of the form
   pim_mul #(.A_W(MW), .B_W(SW)) u_mul_ta (
      .clock(clock), .a(iyy_s), .b(dx2_ff), .p(ta_p));
   pim_mul #(.A_W(MW), .B_W(SW)) u_mul_tb (
      .clock(clock), .a(ixx_s), .b(dy2_ff), .p(tb_p));
   pim_mul #(.A_W(MOMENT_BITS), .B_W(SW)) u_mul_tc (
      .clock(clock), .a(moment_xy), .b(dxy_ff), .p(tc_p));

   // Stage 7: sum the quadratic form
   assign q_in = QW'(ta_p) + QW'(tb_p) - (QW'(tc_p) <<< 1);

   // Stage 8: classify against the determinant
   always_comb begin
      rsp_in.inside_res = 1'b0;
      rsp_in.bad_shape  = 1'b0;
      if (det_d3_ff < 0) begin
         rsp_in.bad_shape = 1'b1;
      end else if (det_d3_ff == 0) begin
         rsp_in.inside_res = (q_ff == 0) && (SUMW'(sq_d3_ff) <= mom_sum);
      end else begin
         rsp_in.inside_res = CMPW'(q_ff) <= CMPW'(det_d3_ff);
      end
   end

   // Advance the data stages every cycle
   always_ff @(posedge clock) begin
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      det_ff    <= det_in;
      sq_ff     <= sq_in;
      dx2_ff    <= dx2_p;
      dy2_ff    <= dy2_p;
      dxy_ff    <= dxy_p;
      det_d1_ff <= det_ff;
      det_d2_ff <= det_d1_ff;
      det_d3_ff <= det_d2_ff;
      sq_d1_ff  <= sq_ff;
      sq_d2_ff  <= sq_d1_ff;
      sq_d3_ff  <= sq_d2_ff;
      q_ff      <= q_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = vld_ff[STAGES-1];
   assign rsp_data   = rsp_ff;

endmodule
